>>> rtl/pcvt_pkg.sv
`timescale 1ns / 1ps
// Package for the polygon convexity test unit: coordinate widths and beat types.
package pcvt_pkg;

	// Coordinate width of one vertex component.
	localparam int COORD_BITS = 16;
	// Edge components are differences of two coordinates.
	localparam int EDGE_BITS = COORD_BITS + 1;
	// Exact product of a pair of edge components.
	localparam int PROD_BITS = 2 * EDGE_BITS;
	// Corners tested per vertex: the regular one plus two wrap-around corners.
	localparam int NUM_CORNERS = 3;
	// Edges needed by those corners.
	localparam int NUM_EDGES = NUM_CORNERS + 1;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] vertex_x;
		logic signed [COORD_BITS-1:0] vertex_y;
		logic                         last_vertex;
	} vertex_t;

	typedef struct packed {
		logic is_convex;
		logic clockwise;
		logic winding_known;
	} result_t;

endpackage

>>> rtl/polygon_convexity_test_unit.sv
`timescale 1ns / 1ps
// Top level of the polygon convexity test unit.
//
// Vertices arrive one beat each. The beat with last_vertex set closes the
// polygon and yields one result beat (is_convex, clockwise, winding_known).
// That result beat follows the closing beat through the input, product and
// result registers, held by stalls. Every vertex from the third on tests the
// corner at the vertex before it; the closing vertex also tests the
// corner at itself and the corner at the first vertex, in that order. Cross
// products are exact: edge differences are COORD_BITS+1 bits and each corner
// uses two replicated multipliers, so one beat is taken per unstalled cycle.
// Zero products are ignored, the first sign mix marks the polygon non-convex
// and freezes the winding flag, and the state restarts after each polygon.
// Polygons of fewer than three vertices report convex with unknown winding.
// The pipeline is an input register, a product register and a result
// register: edges form ahead of the products and the corner signs fold ahead
// of the result. The whole pipeline holds only while a result beat is
// stalled, so vertex_stall follows result_stall in that case alone.
module polygon_convexity_test_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vertex_valid,
	output logic              vertex_stall,
	input  pcvt_pkg::vertex_t vertex,
	output logic              result_valid,
	input  logic              result_stall,
	output pcvt_pkg::result_t result
);

	localparam int CW = pcvt_pkg::COORD_BITS;
	localparam int EW = pcvt_pkg::EDGE_BITS;
	localparam int PW = pcvt_pkg::PROD_BITS;
	localparam int NC = pcvt_pkg::NUM_CORNERS;
	localparam int NE = pcvt_pkg::NUM_EDGES;

	// Vertex counter codes (saturating).
	localparam logic [1:0] SEEN_NONE = 2'd0;
	localparam logic [1:0] SEEN_ONE  = 2'd1;
	localparam logic [1:0] SEEN_TWO  = 2'd2;
	localparam logic [1:0] SEEN_MANY = 2'd3;

	logic advance;
	logic accept;

	// Per-polygon vertex history.
	logic [1:0]          seen_q;
	logic signed [CW-1:0] first_x_q, first_y_q, second_x_q, second_y_q;
	logic signed [CW-1:0] older_x_q, older_y_q, newer_x_q, newer_y_q;

	// Stage 1: the five points that the corners of this vertex need.
	logic                 v_s1, c1_s1, wrap_s1, last_s1;
	logic signed [CW-1:0] ox_s1, oy_s1, nx_s1, ny_s1, xx_s1, xy_s1;
	logic signed [CW-1:0] fx_s1, fy_s1, sx_s1, sy_s1;

	// Edge vectors: older->newer, newer->new, new->first, first->second.
	logic signed [EW-1:0] ex [NE];
	logic signed [EW-1:0] ey [NE];

	// Stage 2: the two cross-product terms of each corner.
	logic                 v_s2, c1_s2, wrap_s2, last_s2;
	logic signed [PW-1:0] pa_s2 [NC];
	logic signed [PW-1:0] pb_s2 [NC];

	// Sign accumulation across corners and vertices.
	logic neg_q, pos_q, wind_q;
	logic neg_d, pos_d, wind_d;

	// Advance everything unless a result beat is parked and stalled.
	assign advance      = !(result_valid && result_stall);
	assign vertex_stall = !advance;
	assign accept       = vertex_valid && advance;

	// Track the vertex history at acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= SEEN_NONE;
		end else if (accept) begin
			if (vertex.last_vertex) begin
				seen_q <= SEEN_NONE;
			end else if (seen_q != SEEN_MANY) begin
				seen_q <= seen_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (seen_q)
				SEEN_NONE: begin
					first_x_q <= vertex.vertex_x;
					first_y_q <= vertex.vertex_y;
				end
				SEEN_ONE: begin
					second_x_q <= vertex.vertex_x;
					second_y_q <= vertex.vertex_y;
					older_x_q  <= newer_x_q;
					older_y_q  <= newer_y_q;
				end
				default: begin
					older_x_q <= newer_x_q;
					older_y_q <= newer_y_q;
				end
			endcase
			newer_x_q <= vertex.vertex_x;
			newer_y_q <= vertex.vertex_y;
		end
	end

	// Stage 1 capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= vertex_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c1_s1   <= (seen_q == SEEN_TWO) || (seen_q == SEEN_MANY);
			wrap_s1 <= vertex.last_vertex && ((seen_q == SEEN_TWO) || (seen_q == SEEN_MANY));
			last_s1 <= vertex.last_vertex;
			ox_s1   <= older_x_q;
			oy_s1   <= older_y_q;
			nx_s1   <= newer_x_q;
			ny_s1   <= newer_y_q;
			xx_s1   <= vertex.vertex_x;
			xy_s1   <= vertex.vertex_y;
			fx_s1   <= first_x_q;
			fy_s1   <= first_y_q;
			sx_s1   <= second_x_q;
			sy_s1   <= second_y_q;
		end
	end

	// Edges, exact in one extra bit.
	always_comb begin
		ex[0] = EW'(nx_s1) - EW'(ox_s1);
		ey[0] = EW'(ny_s1) - EW'(oy_s1);
		ex[1] = EW'(xx_s1) - EW'(nx_s1);
		ey[1] = EW'(xy_s1) - EW'(ny_s1);
		ex[2] = EW'(fx_s1) - EW'(xx_s1);
		ey[2] = EW'(fy_s1) - EW'(xy_s1);
		ex[3] = EW'(sx_s1) - EW'(fx_s1);
		ey[3] = EW'(sy_s1) - EW'(fy_s1);
	end

	// Stage 2: corner k meets edges k and k+1; register both products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			c1_s2   <= c1_s1;
			wrap_s2 <= wrap_s1;
			last_s2 <= last_s1;
			for (int k = 0; k < NC; k++) begin
				pa_s2[k] <= PW'(ex[k]) * PW'(ey[k+1]);
				pb_s2[k] <= PW'(ey[k]) * PW'(ex[k+1]);
			end
		end
	end

	// Fold the corner signs in loop order; stop once the signs have mixed.
	always_comb begin
		neg_d  = neg_q;
		pos_d  = pos_q;
		wind_d = wind_q;
		for (int k = 0; k < NC; k++) begin
			if (((k == 0) ? c1_s2 : wrap_s2) && !(neg_d && pos_d)) begin
				if (pa_s2[k] < pb_s2[k]) begin
					neg_d  = 1'b1;
					wind_d = 1'b1;
				end else if (pa_s2[k] > pb_s2[k]) begin
					pos_d  = 1'b1;
					wind_d = 1'b0;
				end
			end
		end
	end

	// Keep the sign state; drop it after the closing vertex.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q  <= 1'b0;
			pos_q  <= 1'b0;
			wind_q <= 1'b0;
		end else if (advance && v_s2) begin
			if (last_s2) begin
				neg_q  <= 1'b0;
				pos_q  <= 1'b0;
				wind_q <= 1'b0;
			end else begin
				neg_q  <= neg_d;
				pos_q  <= pos_d;
				wind_q <= wind_d;
			end
		end
	end

	// Result register: load on the closing vertex, hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s2 && last_s2) begin
			result.is_convex     <= !(neg_d && pos_d);
			result.winding_known <= neg_d || pos_d;
			result.clockwise     <= (neg_d || pos_d) && wind_d;
		end
	end

endmodule

>>> rtl/pcvt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the polygon convexity test unit, with its bind.
module pcvt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              vertex_valid,
	input logic              vertex_stall,
	input pcvt_pkg::vertex_t vertex,
	input logic              result_valid,
	input logic              result_stall,
	input pcvt_pkg::result_t result
);

	// A stalled vertex beat stays put.
	a_vertex_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && vertex_stall |=> vertex_valid && $stable(vertex))
		else $error("vertex beat changed while stalled");

	// A stalled result beat stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// Vertex stall only comes from a parked, stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_stall |-> result_valid && result_stall)
		else $error("vertex stalled without a stalled result");

	// A sign mix needs nonzero products.
	a_mix_known: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.is_convex |-> result.winding_known)
		else $error("non-convex result without known winding");

	// Unknown winding reports convex and counterclockwise.
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.winding_known |-> result.is_convex && !result.clockwise)
		else $error("unknown winding with inconsistent flags");

endmodule

bind polygon_convexity_test_unit pcvt_checker u_pcvt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.vertex_valid (vertex_valid),
	.vertex_stall (vertex_stall),
	.vertex       (vertex),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

>>> bench/polygon_convexity_test_unit_test.sv
`timescale 1ns / 1ps
// Testbench for the polygon convexity test unit: polygon stimulus, corner-sign predictor, checks.

// Scoreboard: mirrors the corner-sign logic and holds the verdicts still owed.
class convexity_scoreboard;
	pcvt_pkg::result_t expected_verdicts[$];
	int                errors;

	pcvt_pkg::vertex_t first_pt, second_pt, older_pt, newer_pt;
	bit [1:0]          seen;
	bit                neg_seen, pos_seen, turn_cw;

	function new();
		errors = 0;
		seen = 2'd0;
		neg_seen = 1'b0;
		pos_seen = 1'b0;
		turn_cw = 1'b0;
	endfunction

	// Sign of the cross product of edges a->b and b->c, exact in 64 bits.
	function void take_corner(pcvt_pkg::vertex_t a, pcvt_pkg::vertex_t b, pcvt_pkg::vertex_t c);
		longint e1x, e1y, e2x, e2y, turn;
		if (neg_seen && pos_seen)
			return;
		e1x = longint'($signed(b.vertex_x)) - longint'($signed(a.vertex_x));
		e1y = longint'($signed(b.vertex_y)) - longint'($signed(a.vertex_y));
		e2x = longint'($signed(c.vertex_x)) - longint'($signed(b.vertex_x));
		e2y = longint'($signed(c.vertex_y)) - longint'($signed(b.vertex_y));
		turn = e1x * e2y - e1y * e2x;
		if (turn < 0) begin
			neg_seen = 1'b1;
			turn_cw = 1'b1;
		end else if (turn > 0) begin
			pos_seen = 1'b1;
			turn_cw = 1'b0;
		end
	endfunction

	function void note_vertex(pcvt_pkg::vertex_t v);
		pcvt_pkg::result_t r;
		case (seen)
			2'd0: begin
				first_pt = v;
				newer_pt = v;
			end
			2'd1: begin
				second_pt = v;
				older_pt = newer_pt;
				newer_pt = v;
			end
			default: begin
				take_corner(older_pt, newer_pt, v);
				if (v.last_vertex) begin
					take_corner(newer_pt, v, first_pt);
					take_corner(v, first_pt, second_pt);
				end
				older_pt = newer_pt;
				newer_pt = v;
			end
		endcase
		if (seen != 2'd3)
			seen = seen + 2'd1;
		if (!v.last_vertex)
			return;
		r.winding_known = neg_seen || pos_seen;
		r.is_convex = !(neg_seen && pos_seen);
		r.clockwise = r.winding_known && turn_cw;
		expected_verdicts.insert(expected_verdicts.size(), r);
		seen = 2'd0;
		neg_seen = 1'b0;
		pos_seen = 1'b0;
		turn_cw = 1'b0;
	endfunction

	function void check_result(pcvt_pkg::result_t got);
		pcvt_pkg::result_t want;
		if (expected_verdicts.size() == 0) begin
			$error("result beat with no polygon pending");
			errors++;
			return;
		end
		want = expected_verdicts.pop_front();
		if (got.is_convex !== want.is_convex) begin
			$error("is_convex: expected %0d, got %0d", want.is_convex, got.is_convex);
			errors++;
		end
		if (got.clockwise !== want.clockwise) begin
			$error("clockwise: expected %0d, got %0d", want.clockwise, got.clockwise);
			errors++;
		end
		if (got.winding_known !== want.winding_known) begin
			$error("winding_known: expected %0d, got %0d", want.winding_known,
				got.winding_known);
			errors++;
		end
	endfunction
endclass

module polygon_convexity_test_unit_test;

	// Generous ceiling on run length; a healthy run ends far below it.
	localparam int CYCLE_LIMIT = 500000;
	// Random part stops once this many vertex beats went in.
	localparam int VERTEX_TARGET = 1250;
	// Idling settings rotate every this many vertex beats.
	localparam int PHASE_BEATS = 150;
	// Cycles to let the pipeline drain after the last verdict.
	localparam int DRAIN_CYCLES = 8;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              vertex_valid = 1'b0;
	logic              vertex_stall;
	pcvt_pkg::vertex_t vertex = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	pcvt_pkg::result_t result;

	convexity_scoreboard verdicts;
	pcvt_pkg::vertex_t   shape[$];
	int                  beats_sent = 0;
	int                  send_idle_pct = 0;
	int                  stall_pct = 0;
	int                  cycles = 0;

	polygon_convexity_test_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.vertex_valid(vertex_valid),
		.vertex_stall(vertex_stall),
		.vertex      (vertex),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	// 4 ns clock: two ns high, two ns low.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost verdict ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Result side: check the beat taken at this edge against the oldest
	// verdict still owed, then pick the stall for the next cycle. Values read
	// here are the ones present at the edge, since every driver updates late.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			verdicts.check_result(result);
		result_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
	end

	function automatic pcvt_pkg::vertex_t mk_vertex(int x, int y, bit last);
		pcvt_pkg::vertex_t v;
		v.vertex_x = x[pcvt_pkg::COORD_BITS-1:0];
		v.vertex_y = y[pcvt_pkg::COORD_BITS-1:0];
		v.last_vertex = last;
		return v;
	endfunction

	function automatic void add_point(int x, int y);
		shape.insert(shape.size(), mk_vertex(x, y, 1'b0));
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// Offer one vertex beat, idling first at random; hold the payload while
	// stalled and record the beat once it is taken.
	task automatic send_vertex(pcvt_pkg::vertex_t v);
		while ((send_idle_pct != 0) && ($urandom_range(0, 99) < send_idle_pct)) begin
			vertex_valid <= 1'b0;
			@(posedge clk);
		end
		vertex_valid <= 1'b1;
		vertex <= v;
		do
			@(posedge clk);
		while (vertex_stall);
		verdicts.note_vertex(v);
		beats_sent++;
	endtask

	// Send the queued polygon with the flag on its final vertex, then clear it.
	task automatic ship_shape();
		for (int i = 0; i < shape.size(); i++) begin
			shape[i].last_vertex = (i == shape.size() - 1);
			send_vertex(shape[i]);
		end
		shape.delete();
	endtask

	// Convex polygon: a box with its four corners cut off by independent
	// amounts, each cut at most half a side, so every turn goes the same way.
	// Dropping vertices keeps it convex; zero cuts give repeated points and
	// straight runs. Optionally one vertex is moved at random to dent it.
	task automatic make_cut_box();
		int xa, xb, ya, yb, w, h, t, n, start, idx;
		int px[8], py[8], kx[8], ky[8];
		bit rev;
		if ($urandom_range(0, 9) < 4) begin
			xa = int'($urandom_range(0, 200)) - 100;
			xb = xa + int'($urandom_range(0, 40));
			ya = int'($urandom_range(0, 200)) - 100;
			yb = ya + int'($urandom_range(0, 40));
		end else begin
			xa = any_coord();
			xb = any_coord();
			ya = any_coord();
			yb = any_coord();
			if (xa > xb) begin
				t = xa;
				xa = xb;
				xb = t;
			end
			if (ya > yb) begin
				t = ya;
				ya = yb;
				yb = t;
			end
		end
		w = (xb - xa) / 2;
		h = (yb - ya) / 2;
		px[0] = xa + int'($urandom_range(0, w)); py[0] = ya;
		px[1] = xb - int'($urandom_range(0, w)); py[1] = ya;
		px[2] = xb; py[2] = ya + int'($urandom_range(0, h));
		px[3] = xb; py[3] = yb - int'($urandom_range(0, h));
		px[4] = xb - int'($urandom_range(0, w)); py[4] = yb;
		px[5] = xa + int'($urandom_range(0, w)); py[5] = yb;
		px[6] = xa; py[6] = yb - int'($urandom_range(0, h));
		px[7] = xa; py[7] = ya + int'($urandom_range(0, h));
		n = 0;
		for (int i = 0; i < 8; i++) begin
			if ($urandom_range(0, 9) < 7) begin
				kx[n] = px[i];
				ky[n] = py[i];
				n++;
			end
		end
		if (n == 0) begin
			kx[0] = px[0];
			ky[0] = py[0];
			n = 1;
		end
		if ($urandom_range(0, 9) < 3) begin
			idx = int'($urandom_range(0, n - 1));
			kx[idx] = xa + int'($urandom_range(0, xb - xa));
			ky[idx] = ya + int'($urandom_range(0, yb - ya));
		end
		start = int'($urandom_range(0, n - 1));
		rev = 1'($urandom_range(0, 1));
		for (int k = 0; k < n; k++) begin
			idx = rev ? (start - k + n) % n : (start + k) % n;
			add_point(kx[idx], ky[idx]);
		end
	endtask

	// Pick one random polygon: mostly convex shapes with random content, the
	// rest tiny polygons, scattered points and straight lines.
	task automatic make_random_shape();
		int kind, n, x0, y0, dx, dy, k;
		kind = int'($urandom_range(0, 9));
		if (kind == 0) begin
			n = int'($urandom_range(1, 2));
			for (int i = 0; i < n; i++)
				add_point(any_coord(), any_coord());
		end else if (kind <= 2) begin
			n = int'($urandom_range(3, 9));
			for (int i = 0; i < n; i++) begin
				if (kind == 1)
					add_point(any_coord(), any_coord());
				else
					add_point(int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4);
			end
		end else if (kind == 9) begin
			// Points on one line, back and forth: every product is zero
			// unless the stray point at the end is added.
			n = int'($urandom_range(3, 7));
			x0 = int'($urandom_range(0, 2000)) - 1000;
			y0 = int'($urandom_range(0, 2000)) - 1000;
			dx = int'($urandom_range(0, 200)) - 100;
			dy = int'($urandom_range(0, 200)) - 100;
			for (int i = 0; i < n; i++) begin
				k = int'($urandom_range(0, 6));
				add_point(x0 + k * dx, y0 + k * dy);
			end
			if ($urandom_range(0, 1))
				add_point(any_coord(), any_coord());
		end else begin
			make_cut_box();
		end
	endtask

	// Rotate through the idling settings as the beat count grows.
	function automatic void pick_idling();
		case ((beats_sent / PHASE_BEATS) % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 82;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 82;
			end
			default: begin
				send_idle_pct = 34;
				stall_pct = 34;
			end
		endcase
	endfunction

	initial begin
		verdicts = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a lone vertex and a two-vertex polygon at the field
		// extremes (no corner tested, convex with unknown winding).
		add_point(32767, -32768);
		ship_shape();
		add_point(-32768, 32767);
		add_point(32767, 32767);
		ship_shape();
		// Counterclockwise and clockwise triangles spanning the full range.
		add_point(-32768, -32768);
		add_point(32767, -32768);
		add_point(32767, 32767);
		ship_shape();
		add_point(32767, 32767);
		add_point(32767, -32768);
		add_point(-32768, -32768);
		ship_shape();
		// Collinear points only: winding stays unknown.
		add_point(0, 0);
		add_point(5, 5);
		add_point(10, 10);
		ship_shape();
		// Dent at an inner corner: the sign mix shows at the corner before the closing vertex.
		add_point(0, 0);
		add_point(10, 0);
		add_point(2, 2);
		add_point(0, 10);
		ship_shape();
		// Same dent placed first: the mix shows only at the wrap-around
		// corner at the first vertex.
		add_point(2, 2);
		add_point(0, 10);
		add_point(0, 0);
		add_point(10, 0);
		ship_shape();

		// Random polygons, idling settings rotating as they go.
		while (beats_sent < VERTEX_TARGET) begin
			pick_idling();
			make_random_shape();
			ship_shape();
		end
		vertex_valid <= 1'b0;

		// Wait for every verdict owed, then let the pipeline settle.
		while (verdicts.expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (verdicts.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
